// ----- src/serial_frame_receiver_top_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
`ifndef SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");
`else
`define SFR_ASSERT_NOW(label, ante, cons)
`define SFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/sfr_pkg.sv -----
// Constants and codes for the serial frame receiver.
package sfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int FLEN_W      = 6;
  localparam int FIDX_W      = 5;

  localparam logic [BYTE_W-1:0] LEAD_BYTE_RESET = 8'd170;

  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_OPCODE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FLAG   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_PENDING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADLEN  = 2'd2;

endpackage

// ----- src/serial_frame_receiver_top.sv -----
// Serial frame receiver: parses lead/opcode/flag/length/payload frames byte by byte.
// One received byte is taken per request and every byte gives exactly one result request,
// in the cycle after acceptance, from an output register; a new byte is taken in every cycle
// while the result side keeps up (in_ready drops only while a result waits unread).
// The rate of one byte per cycle is set by the phase update on each accepted byte and at
// most one write per byte into the payload RAM (MAX_PAYLOAD bytes, one write port, no clear
// after reset, so the block is ready right out of reset). The lead byte value is written on
// the cfg channel, which is always ready; write it only while the block is idle.
module serial_frame_receiver_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sfr_pkg::STATUS_W-1:0]    status,
  output logic [sfr_pkg::BYTE_W-1:0]      frame_opcode,
  output logic [sfr_pkg::FLEN_W-1:0]      frame_length,
  output logic                            byte_valid,
  output logic [sfr_pkg::FIDX_W-1:0]      byte_index,
  output logic [sfr_pkg::BYTE_W-1:0]      byte_value
);
  import sfr_pkg::*;

  `include "serial_frame_receiver_top_macros.svh"

  logic [BYTE_W-1:0]   lead_byte;
  logic [PHASE_W-1:0]  phase, phase_next;
  logic [BYTE_W-1:0]   opcode_reg, opcode_reg_next;
  logic [LEN_W-1:0]    expected_len, expected_len_next;
  logic [LEN_W-1:0]    received_count, received_count_next;
  logic [LEN_W-1:0]    count_inc;
  logic [STATUS_W-1:0] st;
  logic                store;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign count_inc = received_count + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte <= LEAD_BYTE_RESET;
    end else if (cfg_valid) begin
      lead_byte <= cfg_data;
    end
  end

  always_comb begin
    phase_next          = phase;
    opcode_reg_next     = opcode_reg;
    expected_len_next   = expected_len;
    received_count_next = received_count;
    st                  = ST_PENDING;
    store               = 1'b0;
    case (phase)
      PH_OPCODE: begin
        opcode_reg_next = rx_byte;
        phase_next      = PH_FLAG;
      end
      PH_FLAG: begin
        phase_next = (rx_byte != '0) ? PH_LEAD : PH_LEN;
      end
      PH_LEN: begin
        if (rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
          phase_next = PH_LEAD;
          st         = ST_BADLEN;
        end else begin
          expected_len_next   = LEN_W'(rx_byte);
          received_count_next = '0;
          if (rx_byte == '0) begin
            phase_next = PH_LEAD;
            st         = ST_DONE;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        store               = 1'b1;
        received_count_next = count_inc;
        if (count_inc >= expected_len) begin
          phase_next = PH_LEAD;
          st         = ST_DONE;
        end
      end
      default: begin
        phase_next = (rx_byte == lead_byte) ? PH_OPCODE : PH_LEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEAD;
      opcode_reg     <= '0;
      expected_len   <= '0;
      received_count <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      opcode_reg     <= opcode_reg_next;
      expected_len   <= expected_len_next;
      received_count <= received_count_next;
    end
  end

  // payload buffer is write-only; the read port stays unused
  sfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_PAYLOAD)
  ) u_payload (
    .clk     (clk),
    .we      (accept && store && (received_count < LEN_W'(MAX_PAYLOAD))),
    .wr_addr (ADDR_W'(received_count)),
    .wr_data (rx_byte),
    .rd_addr (ADDR_W'(received_count)),
    .rd_data ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= st;
      frame_opcode <= opcode_reg_next;
      frame_length <= FLEN_W'(expected_len_next);
      byte_valid   <= store;
      byte_index   <= store ? FIDX_W'(received_count) : '0;
      byte_value   <= store ? rx_byte : '0;
    end
  end

  `SFR_ASSERT_NOW(a_no_take_while_full, out_valid && !out_ready, !in_ready)
  `SFR_ASSERT_NOW(a_data_count_in_range, phase == PH_DATA,
                  (expected_len != '0) && (received_count < expected_len))
  `SFR_ASSERT_NOW(a_echo_not_badlen, out_valid && byte_valid, status != ST_BADLEN)
  `SFR_ASSERT_NEXT(a_badlen_resync,
                   accept && (phase == PH_LEN) && (rx_byte > BYTE_W'(MAX_PAYLOAD)),
                   out_valid && (status == ST_BADLEN) && (phase == PH_LEAD))

endmodule

// ----- src/sfr_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
